### sv/dcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drill coordinate decoder package
// Shared constants, types and the power-of-ten table used by the decoder.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int INTERNAL_SCALE = 1000000;
    localparam int MAX_DIGITS     = 12;

    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int DIGIT_W    = 3;
    localparam int COUNT_W    = 4;
    localparam int ACC_W      = 40;
    localparam int EXP_W      = 5;
    localparam int K_W        = 4;
    localparam int VALUE_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INCH_UNITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_DIGITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_DIGITS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILING    = 2'd3;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Scale factors: millimetres carry a factor of 10 and inches 254, and the
    // exponent then divides by one extra power of ten.
    localparam longint unsigned SCALE_MM = longint'(INTERNAL_SCALE) * 10;
    localparam longint unsigned SCALE_IN = longint'(INTERNAL_SCALE) * 254;
    localparam int SCALE_W   = $clog2(SCALE_IN + 1);
    localparam int MUL_STEPS = (SCALE_W + 3) / 4;
    localparam int MUL_BITS  = MUL_STEPS * 4;
    localparam int MUL_CNT_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
    localparam int PROD_W    = ACC_W + MUL_BITS;
    localparam int WORK_W    = PROD_W + 1;
    localparam int CNT_W     = $clog2(WORK_W);

    // Largest divisor is ten to the power MAX_DIGITS + 1.
    localparam int MAX_K = MAX_DIGITS + 1;
    localparam int DIV_W = 44;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                   inch_units;
        logic [CFG_DATA_W-1:0]  integer_digits;
        logic [CFG_DATA_W-1:0]  fraction_digits;
        logic                   trailing_suppressed;
    } t_cfg;

    typedef struct packed {
        logic [ACC_W-1:0]        acc;
        logic signed [EXP_W-1:0] exp;
        logic                    neg;
        logic                    sat;
        logic                    bad;
        logic                    inch;
    } t_job;

    function automatic logic [DIV_W-1:0] f_pow10(input logic [K_W-1:0] k);
        logic [63:0] p;
        unique case (k)
            4'd0:    p = 64'd1;
            4'd1:    p = 64'd10;
            4'd2:    p = 64'd100;
            4'd3:    p = 64'd1000;
            4'd4:    p = 64'd10000;
            4'd5:    p = 64'd100000;
            4'd6:    p = 64'd1000000;
            4'd7:    p = 64'd10000000;
            4'd8:    p = 64'd100000000;
            4'd9:    p = 64'd1000000000;
            4'd10:   p = 64'd10000000000;
            4'd11:   p = 64'd100000000000;
            4'd12:   p = 64'd1000000000000;
            4'd13:   p = 64'd10000000000000;
            default: p = 64'd1;
        endcase
        return p[DIV_W-1:0];
    endfunction

endpackage

### sv/dcd_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drill coordinate decoder channels
// Character input, coordinate output and configuration write channels.
// ----------------------------------------------------------------------------
interface dcd_char_if import dcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              token_end;

    modport source(output valid, output char_code, output token_end, input ready);
    modport sink(input valid, input char_code, input token_end, output ready);
endinterface

interface dcd_coord_if import dcd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] coord_value;
    logic               malformed;
    logic               saturated;

    modport source(output valid, output coord_value, output malformed,
                   output saturated, input ready);
    modport sink(input valid, input coord_value, input malformed,
                 input saturated, output ready);
endinterface

interface dcd_cfg_if import dcd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

### sv/drill_coordinate_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drill coordinate decoder
// Converts drill-file coordinate tokens, one character per item, into
// signed coordinates in internal units with malformed and saturated flags.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the job queue has room; the end
// mark of a token turns it into a job for the arithmetic unit, which holds one
// job at a time. A malformed token goes straight from taking the job to loading
// the result. A well-formed token steps through taking the job, radix-16 scale
// multiplication and a selection step, then either multiply-by-ten for a
// non-negative decimal exponent, or the bit-serial restoring divider that
// rounds a negative exponent, and a final load of the result register. A
// two-entry job queue lets the next tokens be parsed meanwhile, and the result
// register lets a new job run while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module drill_coordinate_decoder import dcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dcd_char_if.sink    i_char,
    dcd_coord_if.source o_coord,
    dcd_cfg_if.sink     i_cfg
);

    t_cfg r_cfg;
    logic w_push_valid;
    logic w_push_ready;
    t_job w_push_job;
    logic w_pop_valid;
    logic w_pop_ready;
    t_job w_pop_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inch_units          <= 1'b0;
            r_cfg.integer_digits      <= CFG_DATA_W'(3);
            r_cfg.fraction_digits     <= CFG_DATA_W'(3);
            r_cfg.trailing_suppressed <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_INCH_UNITS:  r_cfg.inch_units          <= i_cfg.data[0];
                CFG_INT_DIGITS:  r_cfg.integer_digits      <= i_cfg.data;
                CFG_FRAC_DIGITS: r_cfg.fraction_digits     <= i_cfg.data;
                CFG_TRAILING:    r_cfg.trailing_suppressed <= i_cfg.data[0];
            endcase
        end
    end

    dcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (i_char),
        .i_cfg        (r_cfg),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    dcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    dcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (w_pop_valid),
        .o_pop_ready  (w_pop_ready),
        .i_pop_job    (w_pop_job),
        .o_coord      (o_coord)
    );

endmodule

### sv/dcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drill coordinate decoder front end
// Parses token characters and emits one conversion job per token.
// ----------------------------------------------------------------------------
module dcd_front import dcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcd_char_if.sink   i_char,
    input  t_cfg       i_cfg,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_job       o_push_job
);

    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_dap, n_dap;
    logic               r_point, n_point;
    logic               r_neg, n_neg;
    logic               r_bad, n_bad;
    logic               r_ovf, n_ovf;
    logic               r_started;

    logic               w_accept;
    logic [CHAR_W-1:0]  w_c;
    logic [COUNT_W-1:0] w_frac;
    logic [COUNT_W-1:0] w_total;
    logic [COUNT_W-1:0] w_pad;
    logic [EXP_W:0]     w_exp;

    assign i_char.ready = i_push_ready;
    assign w_accept     = i_char.valid && i_push_ready;
    assign w_c          = i_char.char_code;

    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_dap   = r_dap;
        n_point = r_point;
        n_neg   = r_neg;
        n_bad   = r_bad;
        n_ovf   = r_ovf;
        priority if (w_c == CH_PLUS || w_c == CH_MINUS) begin
            if (r_started) begin
                n_bad = 1'b1;
            end else if (w_c == CH_MINUS) begin
                n_neg = 1'b1;
            end
        end else if (w_c == CH_POINT) begin
            if (r_point) begin
                n_bad = 1'b1;
            end
            n_point = 1'b1;
        end else if (w_c >= CH_ZERO && w_c <= CH_NINE) begin
            if (r_cnt < COUNT_W'(MAX_DIGITS)) begin
                n_acc = {r_acc[ACC_W-4:0], 3'b000} + {r_acc[ACC_W-2:0], 1'b0}
                      + ACC_W'(w_c[3:0]);
                n_cnt = r_cnt + 1'b1;
                if (r_point) begin
                    n_dap = r_dap + 1'b1;
                end
            end else begin
                n_ovf = 1'b1;
            end
        end else begin
            n_bad = 1'b1;
        end
    end

    always_comb begin
        w_total = COUNT_W'(i_cfg.integer_digits) + COUNT_W'(i_cfg.fraction_digits);
        w_frac  = n_point ? n_dap : COUNT_W'(i_cfg.fraction_digits);
        if (!n_point && i_cfg.trailing_suppressed && (w_total > n_cnt)) begin
            w_pad = w_total - n_cnt;
        end else begin
            w_pad = '0;
        end
        w_exp = (EXP_W+1)'(w_pad) - (EXP_W+1)'(w_frac) - (EXP_W+1)'(1);
    end

    assign o_push_valid    = i_char.valid && i_char.token_end;
    assign o_push_job.acc  = n_acc;
    assign o_push_job.exp  = w_exp[EXP_W-1:0];
    assign o_push_job.neg  = n_neg;
    assign o_push_job.sat  = n_ovf;
    assign o_push_job.bad  = n_bad || (n_cnt == '0);
    assign o_push_job.inch = i_cfg.inch_units;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cnt     <= '0;
            r_dap     <= '0;
            r_point   <= 1'b0;
            r_neg     <= 1'b0;
            r_bad     <= 1'b0;
            r_ovf     <= 1'b0;
            r_started <= 1'b0;
        end else if (w_accept) begin
            if (i_char.token_end) begin
                r_acc     <= '0;
                r_cnt     <= '0;
                r_dap     <= '0;
                r_point   <= 1'b0;
                r_neg     <= 1'b0;
                r_bad     <= 1'b0;
                r_ovf     <= 1'b0;
                r_started <= 1'b0;
            end else begin
                r_acc     <= n_acc;
                r_cnt     <= n_cnt;
                r_dap     <= n_dap;
                r_point   <= n_point;
                r_neg     <= n_neg;
                r_bad     <= n_bad;
                r_ovf     <= n_ovf;
                r_started <= 1'b1;
            end
        end
    end

endmodule

### sv/dcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drill coordinate decoder job queue
// Small register FIFO that decouples the parser from the arithmetic unit.
// ----------------------------------------------------------------------------
module dcd_queue import dcd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds depth.");
    a_pop_follows_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) && i_push_valid |=> o_pop_valid)
        else $error("A pushed job is not visible at the queue head.");
`endif

endmodule

### sv/dcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drill coordinate decoder back end
// Scales, rounds and clamps one job at a time and holds the result register.
// ----------------------------------------------------------------------------
module dcd_back import dcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    input  t_job       i_pop_job,
    dcd_coord_if.source o_coord
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SEL  = 3'd2;
    localparam logic [2:0] ST_UP   = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]              r_state;
    logic [ACC_W-1:0]        r_acc;
    logic signed [EXP_W-1:0] r_exp;
    logic                    r_neg;
    logic                    r_sat;
    logic                    r_bad;
    logic                    r_inch;
    logic [CNT_W-1:0]        r_cnt;
    logic [WORK_W-1:0]       r_work;
    logic [DIV_W-1:0]        r_div;
    logic [DIV_W-1:0]        r_rem;

    logic                    r_out_valid;
    logic [VALUE_W-1:0]      r_out_value;
    logic                    r_out_malformed;
    logic                    r_out_saturated;

    logic [MUL_BITS-1:0]     w_scale;
    logic [3:0]              w_nib;
    logic [ACC_W+3:0]        w_pp;
    logic [EXP_W-1:0]        w_negexp;
    logic [K_W-1:0]          w_k;
    logic [DIV_W-1:0]        w_pow;
    logic [DIV_W:0]          w_trial;
    logic                    w_ge;
    logic [DIV_W:0]          w_diff;
    logic [35:0]             w_x10;
    logic [WORK_W-1:0]       w_limit;
    logic                    w_over;
    logic [VALUE_W-1:0]      w_mag;
    logic                    w_load;

    assign o_pop_ready = (r_state == ST_IDLE);

    assign w_scale  = r_inch ? MUL_BITS'(SCALE_IN) : MUL_BITS'(SCALE_MM);
    assign w_nib    = w_scale[r_cnt[MUL_CNT_W-1:0]*4 +: 4];
    assign w_pp     = (ACC_W+4)'(r_acc) * (ACC_W+4)'(w_nib);
    assign w_negexp = -r_exp;
    assign w_k      = w_negexp[K_W-1:0];
    assign w_pow    = f_pow10(w_k);
    assign w_trial  = {r_rem, r_work[WORK_W-1]};
    assign w_ge     = (w_trial >= {1'b0, r_div});
    assign w_diff   = w_trial - {1'b0, r_div};
    assign w_x10    = {1'b0, r_work[31:0], 3'b000} + {3'b000, r_work[31:0], 1'b0};
    assign w_limit  = r_neg ? WORK_W'(32'h8000_0000) : WORK_W'(32'h7FFF_FFFF);
    assign w_over   = (r_work > w_limit);
    assign w_mag    = w_over ? w_limit[VALUE_W-1:0] : r_work[VALUE_W-1:0];
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || o_coord.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pop_valid) begin
                        r_state <= i_pop_job.bad ? ST_DONE : ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    r_state <= r_exp[EXP_W-1] ? ST_DIV : ST_UP;
                end
                ST_UP: begin
                    if (w_over || r_cnt == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_acc  <= i_pop_job.acc;
                r_exp  <= i_pop_job.exp;
                r_neg  <= i_pop_job.neg;
                r_sat  <= i_pop_job.sat;
                r_bad  <= i_pop_job.bad;
                r_inch <= i_pop_job.inch;
                r_work <= '0;
                r_cnt  <= CNT_W'(MUL_STEPS - 1);
            end
            ST_MUL: begin
                r_work <= (r_work << 4) + WORK_W'(w_pp);
                r_cnt  <= r_cnt - 1'b1;
            end
            ST_SEL: begin
                if (r_exp[EXP_W-1]) begin
                    r_div  <= w_pow;
                    r_rem  <= '0;
                    r_work <= r_work + WORK_W'(w_pow >> 1);
                    r_cnt  <= CNT_W'(WORK_W - 1);
                end else begin
                    r_cnt  <= CNT_W'(r_exp[EXP_W-2:0]);
                end
            end
            ST_UP: begin
                if (!w_over && r_cnt != '0) begin
                    r_work <= WORK_W'(w_x10);
                    r_cnt  <= r_cnt - 1'b1;
                end
            end
            ST_DIV: begin
                r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
                r_work <= {r_work[WORK_W-2:0], w_ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_bad) begin
                r_out_value     <= '0;
                r_out_malformed <= 1'b1;
                r_out_saturated <= 1'b0;
            end else begin
                r_out_value     <= r_neg ? (~w_mag + 1'b1) : w_mag;
                r_out_malformed <= 1'b0;
                r_out_saturated <= r_sat || w_over;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_coord.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_coord.valid       = r_out_valid;
    assign o_coord.coord_value = r_out_value;
    assign o_coord.malformed   = r_out_malformed;
    assign o_coord.saturated   = r_out_saturated;

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("Divider remainder is not below the divisor.");
    a_mul_to_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) && (r_cnt == '0) |=> (r_state == ST_SEL))
        else $error("Multiplier did not hand over to exponent selection.");
    a_malformed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_malformed |-> (r_out_value == '0) && !r_out_saturated)
        else $error("Malformed result carries a value or a saturation flag.");
    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid && (r_state == ST_IDLE))
        else $error("Result load did not return the unit to idle.");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drill coordinate decoder testbench
// Sends coordinate tokens one character per item under several number
// formats, predicts each coordinate with exact integer arithmetic and checks
// every result field, with random gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module tb import dcd_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               malformed;
        logic               saturated;
    } t_coord_result;

    typedef struct {
        logic [ACC_W-1:0] acc;
        int               n_digits;
        int               n_frac;
        bit               point;
        bit               neg;
        bit               bad;
        bit               ovf;
        bit               started;
    } t_token_state;

    logic i_clk;
    logic i_rst_n;

    dcd_char_if  char_if();
    dcd_coord_if coord_if();
    dcd_cfg_if   cfg_if();

    drill_coordinate_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_coord (coord_if),
        .i_cfg   (cfg_if)
    );

    t_cfg          fmt;
    t_token_state  tok;
    t_coord_result coord_expected[$];
    int            error_count;
    int            chars_accepted;
    int            burst_left;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic void absorb_char(input logic [CHAR_W-1:0] c);
        if (c == CH_PLUS || c == CH_MINUS) begin
            if (tok.started) tok.bad = 1'b1;
            else if (c == CH_MINUS) tok.neg = 1'b1;
        end else if (c == CH_POINT) begin
            if (tok.point) tok.bad = 1'b1;
            tok.point = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (tok.n_digits < MAX_DIGITS) begin
                tok.acc = tok.acc * 10 + ACC_W'(c - CH_ZERO);
                tok.n_digits++;
                if (tok.point) tok.n_frac++;
            end else begin
                tok.ovf = 1'b1;
            end
        end else begin
            tok.bad = 1'b1;
        end
        tok.started = 1'b1;
    endfunction

    function automatic t_coord_result convert_token(input t_token_state t, input t_cfg f);
        t_coord_result r;
        logic [127:0]  prod;
        logic [127:0]  lim;
        logic [127:0]  d;
        logic [127:0]  mag;
        logic          over;
        int            pad;
        int            frac;
        int            total;
        int            e;
        r = '0;
        if (t.bad || t.n_digits == 0) begin
            r.malformed = 1'b1;
            return r;
        end
        lim = t.neg ? 128'd2147483648 : 128'd2147483647;
        pad = 0;
        if (t.point) begin
            frac = t.n_frac;
        end else begin
            frac  = int'(f.fraction_digits);
            total = int'(f.integer_digits) + int'(f.fraction_digits);
            if (f.trailing_suppressed && total > t.n_digits) pad = total - t.n_digits;
        end
        e = pad - frac - 1;
        prod = 128'(t.acc) * (f.inch_units ? 128'd254 : 128'd10) * 128'(INTERNAL_SCALE);
        if (e >= 0) begin
            for (int k = 0; k < e; k++) prod = prod * 10;
        end else begin
            d = 128'd1;
            for (int k = 0; k < -e; k++) d = d * 10;
            prod = (prod + d / 2) / d;
        end
        over = prod > lim;
        mag  = over ? lim : prod;
        r.value     = t.neg ? (32'd0 - mag[31:0]) : mag[31:0];
        r.saturated = t.ovf || over;
        return r;
    endfunction

    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            char_if.valid <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(4, 25)) @(posedge i_clk);
            else repeat ($urandom_range(1, 3)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        char_if.token_end <= last;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        chars_accepted++;
        absorb_char(c);
        if (last) begin
            coord_expected.push_back(convert_token(tok, fmt));
            tok = '{default: 0};
        end
        pace_sender();
    endtask

    task automatic send_chars(input logic [CHAR_W-1:0] s[$]);
        for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
    endtask

    task automatic settle_decoder();
        char_if.valid <= 1'b0;
        while (coord_expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_format(input logic [CFG_DATA_W-1:0] inch_raw,
                                input logic [CFG_DATA_W-1:0] int_raw,
                                input logic [CFG_DATA_W-1:0] frac_raw,
                                input logic [CFG_DATA_W-1:0] trail_raw);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{CFG_INCH_UNITS, CFG_INT_DIGITS, CFG_FRAC_DIGITS, CFG_TRAILING};
        val = '{inch_raw, int_raw, frac_raw, trail_raw};
        for (int i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= val[i];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            case (idx[i])
                CFG_INCH_UNITS:  fmt.inch_units          = val[i][0];
                CFG_INT_DIGITS:  fmt.integer_digits      = val[i];
                CFG_FRAC_DIGITS: fmt.fraction_digits     = val[i];
                CFG_TRAILING:    fmt.trailing_suppressed = val[i][0];
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_digit(input int style);
        int v;
        v = $urandom_range(0, 9);
        if (style == 0) v = 9;
        else if (style == 1 && $urandom_range(0, 3) != 0) v = 0;
        return CH_ZERO + CHAR_W'(v);
    endfunction

    task automatic send_random_token();
        logic [CHAR_W-1:0] s[$];
        int                kind;
        int                n_dig;
        int                pt_pos;
        int                style;
        kind = $urandom_range(0, 99);
        if (kind < 3) begin
            case ($urandom_range(0, 2))
                0:       s.push_back(CH_PLUS);
                1:       s.push_back(CH_MINUS);
                default: s.push_back(CH_POINT);
            endcase
        end else if (kind < 10) begin
            repeat ($urandom_range(1, 6)) s.push_back(CHAR_W'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 2))
                0:       s.push_back(CH_PLUS);
                1:       s.push_back(CH_MINUS);
                default: ;
            endcase
            n_dig  = ($urandom_range(0, 12) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
            pt_pos = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_dig) : -1;
            style  = $urandom_range(0, 5);
            for (int i = 0; i <= n_dig; i++) begin
                if (i == pt_pos) s.push_back(CH_POINT);
                if (i < n_dig) s.push_back(pick_digit(style));
            end
            if (kind >= 90) begin
                case ($urandom_range(0, 3))
                    0:       s.insert($urandom_range(1, s.size()), CH_MINUS);
                    1:       s.insert($urandom_range(0, s.size()), CH_POINT);
                    2:       s.insert($urandom_range(1, s.size()), CH_PLUS);
                    default: s.insert($urandom_range(0, s.size()),
                                      CHAR_W'($urandom_range(0, 255)));
                endcase
            end
        end
        send_chars(s);
    endtask

    task automatic run_random_tokens(input int n_items);
        int target;
        target = chars_accepted + n_items;
        while (chars_accepted < target) send_random_token();
    endtask

    task automatic test_directed_cases();
        send_text("9");
        send_text("-0");
        send_text("+1.5");
        send_text("1..");
        send_text("-");
        send_text("5+");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("-99999999");
    endtask

    task automatic test_format_extremes();
        settle_decoder();
        write_format(3'd1, 3'd6, 3'd6, 3'd0);
        run_random_tokens(180);
        settle_decoder();
        write_format(3'd0, 3'd1, 3'd0, 3'd1);
        run_random_tokens(180);
        settle_decoder();
        write_format(3'd1, 3'd1, 3'd0, 3'd0);
        run_random_tokens(180);
        settle_decoder();
        write_format(3'd0, 3'd6, 3'd6, 3'd1);
        run_random_tokens(180);
    endtask

    task automatic test_unlisted_register_values();
        settle_decoder();
        write_format(3'b110, 3'd0, 3'd7, 3'b011);
        run_random_tokens(120);
        settle_decoder();
        write_format(3'b111, 3'd7, 3'd7, 3'b100);
        run_random_tokens(120);
    endtask

    task automatic test_random_formats();
        repeat (4) begin
            settle_decoder();
            write_format(3'($urandom_range(0, 7)), 3'($urandom_range(1, 6)),
                         3'($urandom_range(0, 6)), 3'($urandom_range(0, 7)));
            run_random_tokens(140);
        end
    endtask

    initial begin
        int rx_mode;
        int rx_stall;
        coord_if.ready <= 1'b0;
        rx_mode  = 0;
        rx_stall = 0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 3);
            if (rx_stall > 0) begin
                rx_stall--;
                coord_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: coord_if.ready <= 1'b1;
                    1: coord_if.ready <= ($urandom_range(0, 3) != 0);
                    2: coord_if.ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        coord_if.ready <= 1'b1;
                        rx_stall = $urandom_range(5, 40);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_coord_result want;
        if (i_rst_n && coord_if.valid && coord_if.ready) begin
            if (coord_expected.size() == 0) begin
                $display("%0t: unexpected coordinate %0d malformed %0b saturated %0b",
                         $time, $signed(coord_if.coord_value), coord_if.malformed,
                         coord_if.saturated);
                error_count++;
            end else begin
                want = coord_expected.pop_front();
                if (coord_if.coord_value !== want.value) begin
                    $display("%0t: coord_value expected %0d, actual %0d", $time,
                             $signed(want.value), $signed(coord_if.coord_value));
                    error_count++;
                end
                if (coord_if.malformed !== want.malformed) begin
                    $display("%0t: malformed expected %0b, actual %0b", $time,
                             want.malformed, coord_if.malformed);
                    error_count++;
                end
                if (coord_if.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %0b, actual %0b", $time,
                             want.saturated, coord_if.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int idle_cycles;
        if ((char_if.valid && char_if.ready) || (coord_if.valid && coord_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        char_if.valid     <= 1'b0;
        char_if.char_code <= '0;
        char_if.token_end <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        i_rst_n           <= 1'b0;
        error_count    = 0;
        chars_accepted = 0;
        burst_left     = 0;
        tok            = '{default: 0};
        fmt.inch_units          = 1'b0;
        fmt.integer_digits      = 3'd3;
        fmt.fraction_digits     = 3'd3;
        fmt.trailing_suppressed = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_format_extremes();
        test_unlisted_register_values();
        test_random_formats();

        settle_decoder();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && coord_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
sv/dcd_pkg.sv
sv/dcd_intf.sv
sv/dcd_front.sv
sv/dcd_queue.sv
sv/dcd_back.sv
sv/drill_coordinate_decoder.sv
tb/sv/tb.sv
